FILE: hw/rtl/xsr_pkg.sv
// Shared types, constants and micro-program for the xoshiro256++ generator.
package xsr_pkg;

	localparam logic [1:0] MODE_SEED   = 2'd0;
	localparam logic [1:0] MODE_DRAW64 = 2'd1;
	localparam logic [1:0] MODE_DRAW32 = 2'd2;

	localparam logic [63:0] GOLDEN     = 64'h9e3779b97f4a7c15;
	localparam logic [63:0] SM_C1      = 64'hbf58476d1ce4e5b9;
	localparam logic [63:0] SM_C2      = 64'h94d049bb133111eb;
	localparam logic [63:0] XH_P1      = 64'h9E3779B185EBCA87;
	localparam logic [63:0] XH_P2      = 64'hC2B2AE3D27D4EB4F;
	localparam logic [63:0] XH_P3      = 64'h165667B19E3779F9;
	localparam logic [63:0] XH_P4      = 64'h85EBCA77C2B2AE63;
	localparam logic [63:0] XH_P5_LEN8 = 64'h27D4EB2F165667CD;

	localparam logic [3:0] LAST_OP = 4'd12;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LOAD,
		ST_MUL0,
		ST_MUL1,
		ST_MUL2,
		ST_MUL3,
		ST_POST
	} ctl_state_t;

	typedef enum logic [2:0] {
		PRE_NONE,
		PRE_ROT31,
		PRE_HMIX,
		PRE_ADD_XS33,
		PRE_XS29,
		PRE_XS30,
		PRE_XS27
	} pre_t;

	typedef enum logic [2:0] {
		K_P1,
		K_P2,
		K_P3,
		K_C1,
		K_C2
	} kconst_t;

	typedef enum logic [1:0] {
		POST_NONE,
		POST_HASH,
		POST_STORE,
		POST_STORE_LAST
	} post_t;

	typedef struct packed {
		pre_t        pre;
		kconst_t     k;
		post_t       post;
		logic [1:0]  word;
	} uop_t;

	typedef struct packed {
		logic        capture_seed;
		logic        draw;
		logic        load_out;
		logic        load_skid;
		logic        move_skid;
		logic        ld_a;
		logic        mul0;
		logic        mul1;
		logic        mul2;
		logic        mul3;
		logic        post;
		logic [3:0]  pc;
	} ctl_cmd_t;

	function automatic logic [63:0] rotl64(input logic [63:0] v, input logic [5:0] n);
		logic [6:0] m;
		m = 7'd64 - {1'b0, n};
		return (v << n) | (v >> m);
	endfunction

	function automatic logic [63:0] kconst(input kconst_t k);
		case (k)
			K_P1:    return XH_P1;
			K_P2:    return XH_P2;
			K_P3:    return XH_P3;
			K_C1:    return SM_C1;
			K_C2:    return SM_C2;
			default: return XH_P1;
		endcase
	endfunction

	// Hash of the counter first, then four splitmix steps of two multiplies each.
	function automatic uop_t micro_op(input logic [3:0] pc);
		case (pc)
			4'd0:    return '{PRE_NONE,     K_P2, POST_NONE,       2'd0};
			4'd1:    return '{PRE_ROT31,    K_P1, POST_NONE,       2'd0};
			4'd2:    return '{PRE_HMIX,     K_P1, POST_NONE,       2'd0};
			4'd3:    return '{PRE_ADD_XS33, K_P2, POST_NONE,       2'd0};
			4'd4:    return '{PRE_XS29,     K_P3, POST_HASH,       2'd0};
			4'd5:    return '{PRE_XS30,     K_C1, POST_NONE,       2'd0};
			4'd6:    return '{PRE_XS27,     K_C2, POST_STORE,      2'd0};
			4'd7:    return '{PRE_XS30,     K_C1, POST_NONE,       2'd1};
			4'd8:    return '{PRE_XS27,     K_C2, POST_STORE,      2'd1};
			4'd9:    return '{PRE_XS30,     K_C1, POST_NONE,       2'd2};
			4'd10:   return '{PRE_XS27,     K_C2, POST_STORE,      2'd2};
			4'd11:   return '{PRE_XS30,     K_C1, POST_NONE,       2'd3};
			4'd12:   return '{PRE_XS27,     K_C2, POST_STORE_LAST, 2'd3};
			default: return '{PRE_NONE,     K_P1, POST_NONE,       2'd0};
		endcase
	endfunction

endpackage

FILE: hw/rtl/xsr_ctrl.sv
// Controller: handshakes, output buffer occupancy and the seeding sequencer.
module xsr_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic [1:0]          mode,
	input  logic                out_stall,
	output logic                in_stall,
	output logic                out_valid,
	output xsr_pkg::ctl_cmd_t   cmd
);

	xsr_pkg::ctl_state_t state_q, state_d;
	logic [3:0] pc_q;
	logic       out_v_q;
	logic       skid_v_q;
	logic       accept;
	logic       is_draw;
	logic       draw;
	logic       seed;
	logic       out_free;

	assign in_stall  = (state_q != xsr_pkg::ST_IDLE) || skid_v_q;
	assign out_valid = out_v_q;
	assign accept    = in_valid && !in_stall;
	assign is_draw   = mode inside {xsr_pkg::MODE_DRAW64, xsr_pkg::MODE_DRAW32};
	assign draw      = accept && is_draw;
	assign seed      = accept && (mode == xsr_pkg::MODE_SEED);
	assign out_free  = !out_v_q || !out_stall;

	always_comb begin
		state_d = state_q;
		case (state_q)
			xsr_pkg::ST_IDLE: begin
				if (seed) begin
					state_d = xsr_pkg::ST_LOAD;
				end
			end
			xsr_pkg::ST_LOAD: state_d = xsr_pkg::ST_MUL0;
			xsr_pkg::ST_MUL0: state_d = xsr_pkg::ST_MUL1;
			xsr_pkg::ST_MUL1: state_d = xsr_pkg::ST_MUL2;
			xsr_pkg::ST_MUL2: state_d = xsr_pkg::ST_MUL3;
			xsr_pkg::ST_MUL3: state_d = xsr_pkg::ST_POST;
			xsr_pkg::ST_POST: begin
				if (pc_q == xsr_pkg::LAST_OP) begin
					state_d = xsr_pkg::ST_IDLE;
				end else begin
					state_d = xsr_pkg::ST_LOAD;
				end
			end
			default: state_d = xsr_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		cmd              = '0;
		cmd.pc           = pc_q;
		cmd.capture_seed = seed;
		cmd.draw         = draw;
		cmd.move_skid    = out_free && skid_v_q;
		cmd.load_out     = out_free && !skid_v_q && draw;
		cmd.load_skid    = !out_free && draw;
		case (state_q)
			xsr_pkg::ST_LOAD: cmd.ld_a = 1'b1;
			xsr_pkg::ST_MUL0: cmd.mul0 = 1'b1;
			xsr_pkg::ST_MUL1: cmd.mul1 = 1'b1;
			xsr_pkg::ST_MUL2: cmd.mul2 = 1'b1;
			xsr_pkg::ST_MUL3: cmd.mul3 = 1'b1;
			xsr_pkg::ST_POST: cmd.post = 1'b1;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= xsr_pkg::ST_IDLE;
			pc_q     <= '0;
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (seed) begin
				pc_q <= '0;
			end else if (state_q == xsr_pkg::ST_POST && pc_q != xsr_pkg::LAST_OP) begin
				pc_q <= pc_q + 4'd1;
			end
			// The skid slot only fills while the output beat is held up.
			if (out_free) begin
				out_v_q  <= skid_v_q || draw;
				skid_v_q <= 1'b0;
			end else if (draw) begin
				skid_v_q <= 1'b1;
			end
		end
	end

endmodule

FILE: hw/rtl/xsr_datapath.sv
// Datapath: state words, seed counter, shared 32x32 multiplier and output buffer.
module xsr_datapath (
	input  logic                clk,
	input  logic                arst_n,
	input  xsr_pkg::ctl_cmd_t   cmd,
	input  logic [1:0]          mode,
	input  logic [63:0]         seed_value,
	output logic [63:0]         random_value
);

	xsr_pkg::uop_t uop;
	logic [63:0] kval;
	logic [63:0] pre_val;
	logic [63:0] add_p4;
	logic [31:0] ma;
	logic [31:0] mb;
	logic [63:0] prod;
	logic [63:0] hash_fin;
	logic [63:0] sm_out;
	logic [63:0] hash_adv;
	logic [63:0] sc_adv;

	logic [63:0] sc_q;
	logic [3:0][63:0] st_q;
	logic [63:0] w_q;
	logic [63:0] a_q;
	logic [63:0] p_q;
	logic [63:0] acc_q;
	logic [63:0] out_q;
	logic [63:0] skid_q;

	logic [63:0] draw_res;
	logic [63:0] draw_val;
	logic [63:0] n0, n1, n2, n3;

	assign uop  = xsr_pkg::micro_op(cmd.pc);
	assign kval = xsr_pkg::kconst(uop.k);
	assign add_p4 = w_q + xsr_pkg::XH_P4;

	always_comb begin
		case (uop.pre)
			xsr_pkg::PRE_NONE:     pre_val = w_q;
			xsr_pkg::PRE_ROT31:    pre_val = xsr_pkg::rotl64(w_q, 6'd31);
			xsr_pkg::PRE_HMIX:     pre_val = xsr_pkg::rotl64(xsr_pkg::XH_P5_LEN8 ^ w_q, 6'd27);
			xsr_pkg::PRE_ADD_XS33: pre_val = add_p4 ^ (add_p4 >> 33);
			xsr_pkg::PRE_XS29:     pre_val = w_q ^ (w_q >> 29);
			xsr_pkg::PRE_XS30:     pre_val = w_q ^ (w_q >> 30);
			xsr_pkg::PRE_XS27:     pre_val = w_q ^ (w_q >> 27);
			default:               pre_val = w_q;
		endcase
	end

	// Low 64 bits of the product from three partial products, one per cycle.
	always_comb begin
		if (cmd.mul1) begin
			ma = a_q[31:0];
			mb = kval[63:32];
		end else if (cmd.mul2) begin
			ma = a_q[63:32];
			mb = kval[31:0];
		end else begin
			ma = a_q[31:0];
			mb = kval[31:0];
		end
	end

	assign prod     = {32'd0, ma} * {32'd0, mb};
	assign hash_fin = acc_q ^ (acc_q >> 32);
	assign hash_adv = hash_fin + xsr_pkg::GOLDEN;
	assign sm_out   = acc_q ^ (acc_q >> 31);
	assign sc_adv   = sc_q + xsr_pkg::GOLDEN;

	// xoshiro256++ output and state update.
	assign draw_res = xsr_pkg::rotl64(st_q[0] + st_q[3], 6'd23) + st_q[0];
	assign n2 = st_q[2] ^ st_q[0];
	assign n3 = st_q[3] ^ st_q[1];
	assign n1 = st_q[1] ^ n2;
	assign n0 = st_q[0] ^ n3;
	assign draw_val = (mode == xsr_pkg::MODE_DRAW32) ? {32'd0, draw_res[63:32]} : draw_res;

	always_ff @(posedge clk) begin
		if (cmd.capture_seed) begin
			w_q <= sc_q ^ seed_value;
		end else if (cmd.post) begin
			case (uop.post)
				xsr_pkg::POST_NONE:  w_q <= acc_q;
				xsr_pkg::POST_HASH:  w_q <= hash_adv;
				xsr_pkg::POST_STORE: w_q <= sc_adv;
				default: ;
			endcase
		end
		if (cmd.ld_a) begin
			a_q <= pre_val;
		end
		if (cmd.mul0 || cmd.mul1 || cmd.mul2) begin
			p_q <= prod;
		end
		if (cmd.mul1) begin
			acc_q <= p_q;
		end else if (cmd.mul2 || cmd.mul3) begin
			acc_q <= acc_q + {p_q[31:0], 32'd0};
		end
		if (cmd.move_skid) begin
			out_q <= skid_q;
		end else if (cmd.load_out) begin
			out_q <= draw_val;
		end
		if (cmd.load_skid) begin
			skid_q <= draw_val;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sc_q <= '0;
			st_q <= '0;
		end else begin
			if (cmd.draw) begin
				st_q[0] <= n0;
				st_q[1] <= n1;
				st_q[2] <= n2 ^ (st_q[1] << 17);
				st_q[3] <= xsr_pkg::rotl64(n3, 6'd45);
			end else if (cmd.post) begin
				case (uop.post)
					xsr_pkg::POST_HASH: sc_q <= hash_adv;
					xsr_pkg::POST_STORE: begin
						sc_q          <= sc_adv;
						st_q[uop.word] <= sm_out;
					end
					xsr_pkg::POST_STORE_LAST: st_q[uop.word] <= sm_out;
					default: ;
				endcase
			end
		end
	end

	assign random_value = out_q;

endmodule

FILE: hw/rtl/xoshiro256pp_prng_with_seeding.sv
// Draw item: result registered in the output slot, or the skid slot while that is held;
// this two-beat buffer absorbs a single stalled beat. Draws sustain one per cycle while
// the skid slot is empty and no seed item runs. Seed item: occupies the shared 32x32
// multiplier sequencer for 13 multiplies; no item is taken meanwhile. Mode 3 is ignored.
// Reset clears the seed counter and all four state words, so draws before seeding give 0.
module xoshiro256pp_prng_with_seeding (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  mode,
	input  logic [63:0] seed_value,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [63:0] random_value
);

	xsr_pkg::ctl_cmd_t cmd;

	xsr_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.mode      (mode),
		.out_stall (out_stall),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.cmd       (cmd)
	);

	xsr_datapath u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.mode         (mode),
		.seed_value   (seed_value),
		.random_value (random_value)
	);

	// A seed beat starts the sequencer, which then holds off the input.
	a_seed_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall && mode == xsr_pkg::MODE_SEED) |=> in_stall)
		else $error("seed beat did not start the sequencer");

	// A draw that meets a held output beat fills the skid slot.
	a_skid_fill: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall && out_valid && out_stall &&
		 (mode == xsr_pkg::MODE_DRAW64 || mode == xsr_pkg::MODE_DRAW32)) |=> in_stall)
		else $error("skid slot not occupied after stalled draw");

	// Multiply phases and the other datapath steps never overlap.
	a_phase_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.ld_a, cmd.mul0, cmd.mul1, cmd.mul2, cmd.mul3, cmd.post, cmd.draw}))
		else $error("overlapping datapath commands");

	// Partial products follow each other cycle by cycle.
	a_mul_seq: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.mul0 |=> cmd.mul1 ##1 cmd.mul2 ##1 cmd.mul3 ##1 cmd.post)
		else $error("multiply sequence broken");

endmodule

FILE: sim/xoshiro256pp_prng_with_seeding_tb.sv
// Self-checking testbench for the seeded xoshiro256++ generator, with an in-line predictor.
`timescale 1ns / 1ps

module xoshiro256pp_prng_with_seeding_tb;

	localparam logic [1:0]  MODE_UNUSED   = 2'd3;
	localparam int unsigned RANDOM_ITEMS  = 1400;
	localparam int unsigned CYCLE_LIMIT   = 400000;
	localparam int unsigned DRAIN_CYCLES  = 100;
	localparam int unsigned HOLD_OFF_LEN  = 250;

	localparam logic [63:0] WEYL_STEP = 64'h9e3779b97f4a7c15;
	localparam logic [63:0] MIX_MUL1  = 64'hbf58476d1ce4e5b9;
	localparam logic [63:0] MIX_MUL2  = 64'h94d049bb133111eb;
	localparam logic [63:0] HASH_P1   = 64'h9E3779B185EBCA87;
	localparam logic [63:0] HASH_P2   = 64'hC2B2AE3D27D4EB4F;
	localparam logic [63:0] HASH_P3   = 64'h165667B19E3779F9;
	localparam logic [63:0] HASH_P4   = 64'h85EBCA77C2B2AE63;
	localparam logic [63:0] HASH_P5   = 64'h27D4EB2F165667C5;

	class prng_scoreboard;
		logic [63:0] seed_ctr;
		logic [63:0] gen_word [4];
		logic [63:0] expected_q [$];
		int unsigned mismatches;

		function new();
			seed_ctr = '0;
			foreach (gen_word[i]) gen_word[i] = '0;
			mismatches = 0;
		endfunction

		function logic [63:0] rotl(logic [63:0] v, int unsigned n);
			return (v << n) | (v >> (64 - n));
		endfunction

		// Hash of a single eight-byte word with a zero hash seed.
		function logic [63:0] hash_counter(logic [63:0] w);
			logic [63:0] h;
			logic [63:0] k;
			h = HASH_P5 + 64'd8;
			k = w * HASH_P2;
			k = rotl(k, 31);
			k = k * HASH_P1;
			h = h ^ k;
			h = rotl(h, 27);
			h = h * HASH_P1 + HASH_P4;
			h = h ^ (h >> 33);
			h = h * HASH_P2;
			h = h ^ (h >> 29);
			h = h * HASH_P3;
			return h ^ (h >> 32);
		endfunction

		function logic [63:0] next_state_word();
			logic [63:0] z;
			seed_ctr = seed_ctr + WEYL_STEP;
			z = seed_ctr;
			z = (z ^ (z >> 30)) * MIX_MUL1;
			z = (z ^ (z >> 27)) * MIX_MUL2;
			return z ^ (z >> 31);
		endfunction

		function logic [63:0] advance_generator();
			logic [63:0] res;
			logic [63:0] t;
			res = rotl(gen_word[0] + gen_word[3], 23) + gen_word[0];
			t = gen_word[1] << 17;
			gen_word[2] = gen_word[2] ^ gen_word[0];
			gen_word[3] = gen_word[3] ^ gen_word[1];
			gen_word[1] = gen_word[1] ^ gen_word[2];
			gen_word[0] = gen_word[0] ^ gen_word[3];
			gen_word[2] = gen_word[2] ^ t;
			gen_word[3] = rotl(gen_word[3], 45);
			return res;
		endfunction

		function void note_input(logic [1:0] item_mode, logic [63:0] item_seed);
			logic [63:0] v;
			case (item_mode)
				xsr_pkg::MODE_SEED: begin
					seed_ctr = hash_counter(seed_ctr ^ item_seed);
					foreach (gen_word[i]) gen_word[i] = next_state_word();
				end
				xsr_pkg::MODE_DRAW64: begin
					expected_q.push_back(advance_generator());
				end
				xsr_pkg::MODE_DRAW32: begin
					v = advance_generator();
					expected_q.push_back({32'h0, v[63:32]});
				end
				default: ;
			endcase
		endfunction

		task report_mismatch(string what, logic [63:0] exp_v, logic [63:0] got_v);
			$display("MISMATCH at %0t: %s: expected %h, got %h", $realtime, what, exp_v, got_v);
			mismatches++;
		endtask

		task check_result(logic [63:0] got);
			logic [63:0] exp_v;
			if (expected_q.size() == 0) begin
				report_mismatch("random_value beat with nothing outstanding", '0, got);
			end else begin
				exp_v = expected_q.pop_front();
				if (got !== exp_v) report_mismatch("random_value", exp_v, got);
			end
		endtask

		function int unsigned pending();
			return expected_q.size();
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [1:0]  mode;
	logic [63:0] seed_value;
	logic        out_valid;
	logic        out_stall;
	logic [63:0] random_value;

	prng_scoreboard sb;
	int unsigned    cycle_count = 0;
	int unsigned    send_idle_pct = 7;
	int unsigned    rx_idle_pct = 7;
	logic           hold_request = 1'b0;

	xoshiro256pp_prng_with_seeding dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.mode         (mode),
		.seed_value   (seed_value),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.random_value (random_value)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// Called at a falling edge; returns at the falling edge after the beat is taken.
	task automatic send_item(input logic [1:0] item_mode, input logic [63:0] item_seed);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid   <= 1'b1;
		mode       <= item_mode;
		seed_value <= item_seed;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		sb.note_input(item_mode, item_seed);
		@(negedge clk);
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		@(negedge clk);
		while (sb.pending() != 0) @(negedge clk);
	endtask

	always @(posedge clk) begin
		cycle_count++;
		if (arst_n && out_valid && !out_stall) sb.check_result(random_value);
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	// Receiver: random stalls, plus one long hold-off counted here once requested.
	initial begin
		int unsigned hold_left;
		bit          hold_taken;
		hold_left  = 0;
		hold_taken = 1'b0;
		out_stall  = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_request && !hold_taken) begin
				hold_taken = 1'b1;
				hold_left  = HOLD_OFF_LEN;
			end
			if (hold_left != 0) begin
				out_stall <= 1'b1;
				hold_left--;
			end else begin
				out_stall <= ($urandom_range(99) < rx_idle_pct);
			end
		end
	end

	initial begin
		int unsigned n_items;
		int unsigned idx;
		int unsigned pick;
		logic [1:0]  item_mode;
		logic [63:0] item_seed;

		arst_n     = 1'b0;
		in_valid   = 1'b0;
		mode       = xsr_pkg::MODE_SEED;
		seed_value = '0;
		sb = new();
		repeat (12) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Unseeded generator first: every draw gives zero, and an unused mode changes nothing; then seeds and draws.
		send_item(xsr_pkg::MODE_DRAW64, '0);
		send_item(xsr_pkg::MODE_DRAW32, '1);
		send_item(MODE_UNUSED, 64'hdead_beef_0123_4567);
		send_item(xsr_pkg::MODE_DRAW64, '0);
		send_item(xsr_pkg::MODE_SEED, '0);
		send_item(xsr_pkg::MODE_DRAW64, '0);
		send_item(xsr_pkg::MODE_DRAW64, '1);
		send_item(xsr_pkg::MODE_DRAW32, '0);
		send_item(xsr_pkg::MODE_SEED, '1);
		send_item(xsr_pkg::MODE_DRAW64, '0);
		send_item(xsr_pkg::MODE_DRAW32, '1);
		send_item(xsr_pkg::MODE_SEED, 64'h8000_0000_0000_0001);
		send_item(xsr_pkg::MODE_SEED, 64'h5555_5555_aaaa_aaaa);
		send_item(xsr_pkg::MODE_DRAW64, '0);
		send_item(MODE_UNUSED, '1);
		send_item(xsr_pkg::MODE_DRAW64, '0);
		send_item(xsr_pkg::MODE_DRAW32, '0);
		send_item(xsr_pkg::MODE_SEED, {$urandom, $urandom});
		send_item(xsr_pkg::MODE_DRAW32, '0);
		send_item(xsr_pkg::MODE_DRAW64, '0);
		send_item(xsr_pkg::MODE_DRAW64, '0);

		n_items = 0;
		idx = 0;
		while (n_items < RANDOM_ITEMS) begin
			if (idx == 300) wait_drained();
			if (idx == 500) begin
				send_idle_pct = 0;
				rx_idle_pct   = 0;
			end
			if (idx == 800) begin
				send_idle_pct = 7;
				rx_idle_pct   = 7;
			end
			if (idx == 900) hold_request <= 1'b1;

			pick = $urandom_range(99);
			if (idx >= 900 && idx < 960)
				item_mode = pick[0] ? xsr_pkg::MODE_DRAW64 : xsr_pkg::MODE_DRAW32;
			else if (pick < 6)
				item_mode = xsr_pkg::MODE_SEED;
			else if (pick < 9)
				item_mode = MODE_UNUSED;
			else if (pick < 55)
				item_mode = xsr_pkg::MODE_DRAW64;
			else
				item_mode = xsr_pkg::MODE_DRAW32;

			case ($urandom_range(7))
				0:       item_seed = '0;
				1:       item_seed = '1;
				2:       item_seed = 64'd1 << $urandom_range(63);
				default: item_seed = {$urandom, $urandom};
			endcase

			send_item(item_mode, item_seed);
			if (item_mode != MODE_UNUSED) n_items++;
			idx++;
		end

		wait_drained();
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (sb.mismatches == 0 && sb.pending() == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule

FILE: xoshiro256pp_prng_with_seeding.f
hw/rtl/xsr_pkg.sv
hw/rtl/xsr_ctrl.sv
hw/rtl/xsr_datapath.sv
hw/rtl/xoshiro256pp_prng_with_seeding.sv
sim/xoshiro256pp_prng_with_seeding_tb.sv
